/* rtl/core/sacl_pkg.sv */
// shared types, constants and helpers of the set-associative lru tag store
package sacl_pkg;

  localparam int DEF_WAYS      = 8;
  localparam int DEF_MAX_SETS  = 2048;
  localparam int DEF_ADDR_BITS = 32;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int OFFSET_W   = 4;
  localparam int INDEX_W    = 4;
  localparam int SHAMT_W    = 5;
  localparam int WAY_OUT_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 4'd4;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_INDEX_BITS  = 1'b1
  } cfg_reg_t;

  // one way of a set row, valid in the lowest bit
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    logic               valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // largest k with 2**k not above n
  function automatic int floor_log2(input int n);
    int k;
    k = 0;
    for (int i = 1; i < 31; i++) begin
      if ((64'd1 << i) <= 64'(n)) k = i;
    end
    return k;
  endfunction

endpackage

/* rtl/core/sacl_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sacl_way_sel.sv */
// hit detection and lru victim choice over one set row
module sacl_way_sel import sacl_pkg::*; #(
  parameter int WAYS = DEF_WAYS,
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [WAYS*ENTRY_W-1:0] row,
  input  logic [TAG_W-1:0]        tag,
  output logic                    hit,
  output logic [WAY_W-1:0]        way
);

  entry_t          ent [WAYS];
  logic [WAYS-1:0] match;
  logic [WAYS-1:0] vld;
  logic [WAYS-1:0] oldest;
  logic [WAYS-1:0] cand;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    assign ent[w]   = row[w*ENTRY_W +: ENTRY_W];
    assign vld[w]   = ent[w].valid;
    assign match[w] = ent[w].valid && (ent[w].tag == tag);
  end

  // way w is the victim if strictly older than every lower way and no newer than any higher one
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      oldest[w] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (j < w && !(ent[w].stamp < ent[j].stamp)) oldest[w] = 1'b0;
        if (j > w && !(ent[w].stamp <= ent[j].stamp)) oldest[w] = 1'b0;
      end
    end
  end

  assign hit = |match;

  always_comb begin
    if (hit) begin
      cand = match;
    end else if (!(&vld)) begin
      cand = ~vld;
    end else begin
      cand = oldest;
    end
    // lowest candidate wins
    way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cand[w]) way = WAY_W'(w);
    end
  end

endmodule

/* rtl/core/set_assoc_cache_lru.sv */
// set_assoc_cache_lru: tag store of a WAYS-way set-associative cache with lru replacement.
// Each input item is a byte address; each result item gives hit, the way hit or filled, and
// the saturating access and miss counts. The set row is read from the tag ram in the accept
// cycle; tag compare, victim choice and row write-back follow in the eval state, which waits
// while the last result is not yet taken. A new item is taken the cycle after write-back, so
// same-set items never overlap. After reset a clearing pass writes every set row once
// (MAX_SETS, 2048 by default) before the first item; configuration writes are taken at any time.
module set_assoc_cache_lru import sacl_pkg::*; #(
  parameter int WAYS      = DEF_WAYS,
  parameter int MAX_SETS  = DEF_MAX_SETS,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // address[31:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // hit, way[2:0], access_total[31:0], miss_total[31:0]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_MAX = floor_log2(MAX_SETS);
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W   = WAYS * ENTRY_W;
  localparam logic [SHAMT_W-1:0] IDX_CAP  = SHAMT_W'(IDX_MAX);
  localparam logic [SET_W-1:0]   SET_LAST = SET_W'(MAX_SETS - 1);
  localparam logic [ADDR_W-1:0]  ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [SET_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [OFFSET_W-1:0]  offset_r;
  logic [INDEX_W-1:0]   index_r;
  logic [SET_W-1:0]     set_r;
  logic [TAG_W-1:0]     tag_r;
  logic [CNT_W-1:0]     acc_cnt_r, acc_cnt_nxt;
  logic [CNT_W-1:0]     miss_cnt_r, miss_cnt_nxt;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic [CNT_W-1:0]     out_acc_r;
  logic [CNT_W-1:0]     out_miss_r;

  logic [ADDR_W-1:0]    addr;
  logic [SHAMT_W-1:0]   idx_eff;
  logic [SHAMT_W-1:0]   tag_shamt;
  logic [ADDR_W-1:0]    set_full;
  logic [SET_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;
  logic                 in_fire;
  logic                 eval_go;
  logic                 ram_we;
  logic [SET_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     row_q;
  logic [ROW_W-1:0]     row_new;
  logic                 sel_hit;
  logic [WAY_W-1:0]     sel_way;
  logic [WAY_W+2:0]     way_ext;

  // address split with index bits clamped to the set count
  assign addr      = in_tdata & ADDR_MASK;
  assign idx_eff   = ({1'b0, index_r} > IDX_CAP) ? IDX_CAP : {1'b0, index_r};
  assign tag_shamt = {1'b0, offset_r} + idx_eff;
  assign set_full  = (addr >> offset_r) & ((ADDR_W'(1) << idx_eff) - ADDR_W'(1));
  assign set_in    = set_full[SET_W-1:0];
  assign tag_in    = addr >> tag_shamt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign eval_go   = (state_r == ST_EVAL) && (!out_valid_r || out_tready);

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (set_in),
    .rdata (row_q)
  );

  sacl_way_sel #(
    .WAYS (WAYS)
  ) u_way_sel (
    .row (row_q),
    .tag (tag_r),
    .hit (sel_hit),
    .way (sel_way)
  );

  assign acc_cnt_nxt  = (&acc_cnt_r) ? acc_cnt_r : acc_cnt_r + CNT_W'(1);
  assign miss_cnt_nxt = (sel_hit || (&miss_cnt_r)) ? miss_cnt_r : miss_cnt_r + CNT_W'(1);

  // the chosen way gets the tag and the new stamp, on a hit the tag is unchanged
  for (genvar w = 0; w < WAYS; w++) begin : g_row
    entry_t upd;
    assign upd.stamp = acc_cnt_nxt;
    assign upd.tag   = tag_r;
    assign upd.valid = 1'b1;
    assign row_new[w*ENTRY_W +: ENTRY_W] =
      (sel_way == WAY_W'(w)) ? upd : row_q[w*ENTRY_W +: ENTRY_W];
  end

  assign ram_we    = (state_r == ST_CLEAR) || eval_go;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : set_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : row_new;

  assign way_ext = {3'b000, sel_way};

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        if (clr_cnt_r == SET_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      offset_r    <= OFFSET_RST;
      index_r     <= INDEX_RST;
      acc_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_OFFSET_BITS: offset_r <= cfg_wdata[OFFSET_W-1:0];
          CFG_INDEX_BITS:  index_r  <= cfg_wdata[INDEX_W-1:0];
          default:         offset_r <= offset_r;
        endcase
      end
      if (eval_go) begin
        acc_cnt_r   <= acc_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r <= set_in;
      tag_r <= tag_in;
    end
    if (eval_go) begin
      out_hit_r  <= sel_hit;
      out_way_r  <= way_ext[WAY_OUT_W-1:0];
      out_acc_r  <= acc_cnt_nxt;
      out_miss_r <= miss_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_miss_r, out_acc_r, out_way_r, out_hit_r};

endmodule

/* bench/tb_set_assoc_cache_lru.sv */
// testbench for the set-associative lru tag store: directed table, random lookups, self-check
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru import sacl_pkg::*;;

  localparam int N_DIR       = 26;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct packed {
    logic             hit;
    logic [2:0]       way;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] miss_total;
  } lookup_t;

  typedef struct packed {
    logic                is_split;
    logic [OFFSET_W-1:0] off;
    logic [INDEX_W-1:0]  idx;
    logic [ADDR_W-1:0]   addr;
    logic                typed;
    lookup_t             res;
  } row_t;

  // typed results only right after reset; everything else comes from the predictor
  localparam row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, 4'd0,  4'd0,  32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd1, 32'd1}},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0000, 1'b1, '{1'b1, 3'd0, 32'd2, 32'd1}},
    '{1'b0, 4'd0,  4'd0,  32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'd3, 32'd2}},
    '{1'b0, 4'd0,  4'd0,  32'h0000_000F, 1'b1, '{1'b1, 3'd0, 32'd4, 32'd2}},
    // one set, no offset: old tags stay, fill all ways, then evict
    '{1'b1, 4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0001, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0002, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0003, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0004, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0005, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0006, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0007, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0008, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
    // largest offset, index bits above the set count get clamped
    '{1'b1, 4'd15, 4'd15, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h8000_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0400_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h07FF_FFFF, 1'b0, '0},
    '{1'b1, 4'd8,  4'd11, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h1234_5678, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h1234_5600, 1'b0, '0},
    '{1'b1, 4'd4,  4'd5,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'h0000_0000, 1'b0, '0},
    '{1'b0, 4'd0,  4'd0,  32'hFFFF_FFF0, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = CFG_OFFSET_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  bit                  line_valid [DEF_MAX_SETS][DEF_WAYS];
  logic [TAG_W-1:0]    line_tag   [DEF_MAX_SETS][DEF_WAYS];
  logic [STAMP_W-1:0]  line_stamp [DEF_MAX_SETS][DEF_WAYS];
  logic [CNT_W-1:0]    access_cnt = '0;
  logic [CNT_W-1:0]    miss_cnt = '0;
  logic [OFFSET_W-1:0] split_offset = OFFSET_RST;
  logic [INDEX_W-1:0]  split_index = INDEX_RST;

  lookup_t lookup_q [$];
  int      mismatch_cnt = 0;
  int      idle_cycles = 0;
  int      in_gap_max = 17;
  int      out_gap_max = 17;
  int      hold_off = 0;

  set_assoc_cache_lru u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // index bits actually used: no more sets than the store holds
  function automatic int used_index_bits(logic [INDEX_W-1:0] req);
    int k;
    k = 0;
    while (k < req && (64'd1 << (k + 1)) <= 64'(DEF_MAX_SETS)) k++;
    return k;
  endfunction

  function automatic lookup_t predict_lookup(logic [ADDR_W-1:0] addr);
    int               ib;
    int               set_no;
    int               sel;
    bit               found;
    logic [TAG_W-1:0] tag;
    logic [STAMP_W-1:0] best;
    lookup_t          r;
    ib = used_index_bits(split_index);
    set_no = int'((addr >> split_offset) & ((32'd1 << ib) - 32'd1));
    tag = addr >> (split_offset + ib);
    if (access_cnt != '1) access_cnt++;
    found = 1'b0;
    sel = 0;
    for (int w = 0; w < DEF_WAYS; w++) begin
      if (!found && line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
        found = 1'b1;
        sel = w;
      end
    end
    r.hit = found;
    if (!found) begin
      if (miss_cnt != '1) miss_cnt++;
      for (int w = DEF_WAYS - 1; w >= 0; w--) begin
        if (!line_valid[set_no][w]) begin
          found = 1'b1;
          sel = w;
        end
      end
      // all ways valid: oldest stamp, lowest way on a tie
      if (!found) begin
        best = line_stamp[set_no][0];
        for (int w = 1; w < DEF_WAYS; w++) begin
          if (line_stamp[set_no][w] < best) begin
            best = line_stamp[set_no][w];
            sel = w;
          end
        end
      end
      line_valid[set_no][sel] = 1'b1;
      line_tag[set_no][sel] = tag;
    end
    line_stamp[set_no][sel] = access_cnt;
    r.way = 3'(sel);
    r.access_total = access_cnt;
    r.miss_total = miss_cnt;
    return r;
  endfunction

  task automatic send_addr(input logic [ADDR_W-1:0] addr, input logic typed,
                           input lookup_t typed_res);
    int      gap;
    lookup_t want;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= addr;
    do @(posedge clk); while (!in_tready);
    want = predict_lookup(addr);
    if (typed) want = typed_res;
    lookup_q.push_back(want);
  endtask

  // registers change only with the block drained
  task automatic set_split(input logic [OFFSET_W-1:0] off, input logic [INDEX_W-1:0] idx);
    in_tvalid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OFFSET_BITS;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_index <= CFG_INDEX_BITS;
    cfg_wdata <= idx;
    @(posedge clk);
    cfg_we <= 1'b0;
    split_offset = off;
    split_index = idx;
  endtask

  initial begin : stim
    row_t              row;
    int                ib;
    int                sh;
    logic [ADDR_W-1:0] tag_base;
    logic [ADDR_W-1:0] set_base;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] off_mask;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.is_split) set_split(row.off, row.idx);
      else send_addr(row.addr, row.typed, row.res);
    end
    for (int p = 0; p < N_PHASES; p++) begin
      set_split(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      in_gap_max = (p == 1 || p == 2 || p == 4) ? 0 : 17;
      out_gap_max = (p == 1 || p == 3) ? 0 : 17;
      // receiver stalls long while items keep coming
      if (p == 2) hold_off = 400;
      ib = used_index_bits(split_index);
      sh = split_offset + ib;
      off_mask = (32'd1 << split_offset) - 32'd1;
      tag_base = $urandom;
      set_base = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          // small working set: 12 tags over up to 4 sets forces hits and evictions
          addr = ((tag_base + 32'($urandom_range(0, 11))) << sh)
               | ((((set_base + 32'($urandom_range(0, 3))) & ((32'd1 << ib) - 32'd1)))
                  << split_offset)
               | (32'($urandom) & off_mask);
        end else begin
          addr = $urandom;
        end
        send_addr(addr, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && lookup_q.size() == 0) begin
      $display("set_assoc_cache_lru: match");
    end else begin
      $display("set_assoc_cache_lru: mismatch");
    end
    $finish;
  end

  initial begin : rx_side
    int      stall;
    lookup_t got;
    lookup_t want;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off != 0) stall = hold_off;
      else stall = $urandom_range(0, out_gap_max);
      hold_off = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.hit = out_tdata[0];
      got.way = out_tdata[3:1];
      got.access_total = out_tdata[35:4];
      got.miss_total = out_tdata[67:36];
      if (lookup_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result item with nothing expected, got %h", $time, got);
      end else begin
        want = lookup_q.pop_front();
        if (got.hit !== want.hit) begin
          mismatch_cnt++;
          $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
        end
        if (got.way !== want.way) begin
          mismatch_cnt++;
          $display("%0t: way expected %0d got %0d", $time, want.way, got.way);
        end
        if (got.access_total !== want.access_total) begin
          mismatch_cnt++;
          $display("%0t: access_total expected %0d got %0d", $time,
                   want.access_total, got.access_total);
        end
        if (got.miss_total !== want.miss_total) begin
          mismatch_cnt++;
          $display("%0t: miss_total expected %0d got %0d", $time,
                   want.miss_total, got.miss_total);
        end
      end
    end
  end

  // limit covers the clearing pass after reset plus the long receiver hold-off
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("set_assoc_cache_lru: mismatch");
      $finish;
    end
  end

endmodule
